// File: src/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// shared types and constants for the affine point transform pipeline
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int COORD_W     = 32;
  localparam int ROWS        = 3;
  localparam int COLS        = 4;
  localparam int COEFF_COUNT = ROWS * COLS;
  localparam int IDX_W       = 4;
  // a 32x32 signed product fits in 64 bits
  localparam int PROD_W      = 2 * COORD_W;
  // three products plus the translation term need two guard bits
  localparam int SUM_W       = PROD_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [IDX_W-1:0]          idx_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_POINT = 1'b1
  } kind_t;

  // register load enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

// File: src/apt_coeff_store.sv
// ----------------------------------------------------------------------------
// apt_coeff_store
// twelve matrix coefficients, reset to identity, loaded one per transfer
// ----------------------------------------------------------------------------
module apt_coeff_store #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           load_en,
  input  apt_pkg::idx_t  load_index,
  input  apt_pkg::coord_t load_value,
  output apt_pkg::coord_t coeff [apt_pkg::COEFF_COUNT]
);
  import apt_pkg::*;

  localparam coord_t ONE = coord_t'(1) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          coeff[r*COLS+c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (load_en && (load_index < idx_t'(COEFF_COUNT))) begin
      coeff[load_index] <= load_value;
    end
  end

endmodule

// File: src/apt_product.sv
// ----------------------------------------------------------------------------
// apt_product
// stage 1: nine coefficient by coordinate products, translation captured
// ----------------------------------------------------------------------------
module apt_product (
  input  logic             clk,
  input  logic             rst,
  input  apt_pkg::pipe_en_t en,
  input  logic             in_valid,
  input  apt_pkg::coord_t  point_x,
  input  apt_pkg::coord_t  point_y,
  input  apt_pkg::coord_t  point_z,
  input  apt_pkg::coord_t  coeff [apt_pkg::COEFF_COUNT],
  output logic             valid,
  output apt_pkg::prod_t   prod  [apt_pkg::ROWS][3],
  output apt_pkg::coord_t  trans [apt_pkg::ROWS]
);
  import apt_pkg::*;

  coord_t pt [3];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en.s1) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1 && in_valid) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= prod_t'(coeff[r*COLS+c]) * prod_t'(pt[c]);
        end
        trans[r] <= coeff[r*COLS+3];
      end
    end
  end

endmodule

// File: src/apt_sum.sv
// ----------------------------------------------------------------------------
// apt_sum
// stages 2 and 3: pairwise sums, then the full row sum
// ----------------------------------------------------------------------------
module apt_sum #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  apt_pkg::pipe_en_t en,
  input  logic              in_valid,
  input  apt_pkg::prod_t    prod  [apt_pkg::ROWS][3],
  input  apt_pkg::coord_t   trans [apt_pkg::ROWS],
  output logic              valid_mid,
  output logic              valid,
  output apt_pkg::sum_t     total [apt_pkg::ROWS]
);
  import apt_pkg::*;

  sum_t sum_a [ROWS];
  sum_t sum_b [ROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_mid <= 1'b0;
      valid     <= 1'b0;
    end else begin
      if (en.s2) begin
        valid_mid <= in_valid;
      end
      if (en.s3) begin
        valid <= valid_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2 && in_valid) begin
      for (int r = 0; r < ROWS; r++) begin
        sum_a[r] <= sum_t'(prod[r][0]) + sum_t'(prod[r][1]);
        // translation times one is the coefficient moved up by the fraction
        sum_b[r] <= sum_t'(prod[r][2]) + (sum_t'(trans[r]) <<< FRAC_BITS);
      end
    end
    if (en.s3 && valid_mid) begin
      for (int r = 0; r < ROWS; r++) begin
        total[r] <= sum_a[r] + sum_b[r];
      end
    end
  end

endmodule

// File: src/apt_round_sat.sv
// ----------------------------------------------------------------------------
// apt_round_sat
// stage 4: floor shift by the fraction width and saturate to 32 bits
// ----------------------------------------------------------------------------
module apt_round_sat #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  apt_pkg::pipe_en_t en,
  input  logic              in_valid,
  input  apt_pkg::sum_t     total [apt_pkg::ROWS],
  output logic              valid,
  output apt_pkg::coord_t   res   [apt_pkg::ROWS]
);
  import apt_pkg::*;

  localparam sum_t SAT_HI = (sum_t'(1) <<< (COORD_W - 1)) - sum_t'(1);
  localparam sum_t SAT_LO = -(sum_t'(1) <<< (COORD_W - 1));

  sum_t shifted [ROWS];

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      shifted[r] = total[r] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en.s4) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4 && in_valid) begin
      for (int r = 0; r < ROWS; r++) begin
        if (shifted[r] > SAT_HI) begin
          res[r] <= SAT_HI[COORD_W-1:0];
        end else if (shifted[r] < SAT_LO) begin
          res[r] <= SAT_LO[COORD_W-1:0];
        end else begin
          res[r] <= shifted[r][COORD_W-1:0];
        end
      end
    end
  end

endmodule

// File: src/affine_point_transform_core.sv
// ----------------------------------------------------------------------------
// affine_point_transform_core
// 3d point transform by the top three rows of an affine 4x4 matrix, w = 1
// ----------------------------------------------------------------------------
// pipeline: a point passes four register stages; output stalls hold them back
// throughput: one point per cycle while item_stall is low; a coefficient load gives no result
// the rate is set by the four register stages, each of which can take a new
// item in every cycle; an empty stage fills even while the output is stalled
// reset: clears all stage valid bits and sets the matrix to identity
// ----------------------------------------------------------------------------
module affine_point_transform_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  // item channel
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                kind,
  input  logic [3:0]          coeff_index,
  input  logic signed [31:0]  coeff_value,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z
);
  import apt_pkg::*;

  coord_t   coeff [COEFF_COUNT];
  prod_t    prod  [ROWS][3];
  coord_t   trans [ROWS];
  sum_t     total [ROWS];
  coord_t   res   [ROWS];
  pipe_en_t en;

  logic v1;
  logic v2;
  logic v3;
  logic load_en;
  logic point_in;

  // each stage loads when it is empty or its content moves on
  always_comb begin
    en.s4 = !result_valid || !result_stall;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign item_stall = !en.s1;

  // loads act at the transfer itself; points go down the pipeline
  assign load_en  = item_valid && en.s1 && (kind_t'(kind) == KIND_LOAD);
  assign point_in = item_valid && (kind_t'(kind) == KIND_POINT);

  // matrix store, read by stage 1 in the cycle of the point transfer
  apt_coeff_store #(
    .FRAC_BITS (FRAC_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .load_en    (load_en),
    .load_index (coeff_index),
    .load_value (coeff_value),
    .coeff      (coeff)
  );

  // stage 1: products
  apt_product u_product (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (point_in),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .coeff    (coeff),
    .valid    (v1),
    .prod     (prod),
    .trans    (trans)
  );

  // stages 2 and 3: row sums at full width
  apt_sum #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .prod      (prod),
    .trans     (trans),
    .valid_mid (v2),
    .valid     (v3),
    .total     (total)
  );

  // stage 4: shift, saturate, output register
  apt_round_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round_sat (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .total    (total),
    .valid    (result_valid),
    .res      (res)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];

  // input only stalls when every stage holds an item and the output waits
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (v1 && v2 && v3 && result_valid && result_stall))
    else $error("input stalled with a free pipeline stage");

  // a load lands in the store on the following cycle
  a_load_lands: assert property (@(posedge clk) disable iff (rst)
    (load_en && (coeff_index < idx_t'(COEFF_COUNT)))
      |=> (coeff[$past(coeff_index)] == $past(coeff_value)))
    else $error("coefficient load lost");

  // stage 1 content moving on is never dropped
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (v1 && en.s2) |=> v2)
    else $error("item lost between stage 1 and stage 2");

  // nothing valid straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !v1 && !v2 && !v3))
    else $error("pipeline not empty after reset");

endmodule

// File: dv/apt_tb_pkg.sv
// ----------------------------------------------------------------------------
// apt_tb_pkg
// expected-result tracking for the affine point transform bench: a copy of
// the coefficient matrix and a queue of transformed points still to come out
// ----------------------------------------------------------------------------
package apt_tb_pkg;

  import apt_pkg::*;

  // saturation bounds held at accumulator width
  localparam sum_t Q_MAX = (sum_t'(1) <<< 31) - sum_t'(1);
  localparam sum_t Q_MIN = -(sum_t'(1) <<< 31);

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  class transform_board;
    int     frac;
    coord_t matrix[COEFF_COUNT];
    point_t due[$];
    int     errors;

    function new(int frac_bits);
      frac   = frac_bits;
      errors = 0;
      foreach (matrix[i]) matrix[i] = '0;
      // identity on the diagonal
      for (int r = 0; r < ROWS; r++) matrix[r * COLS + r] = coord_t'(1) <<< frac;
    endfunction

    // dot product of one row with (x, y, z, 1), floored and clamped
    function coord_t row_result(int r, coord_t x, coord_t y, coord_t z);
      sum_t acc;
      sum_t q;
      acc = sum_t'(matrix[r * COLS])     * sum_t'(x)
          + sum_t'(matrix[r * COLS + 1]) * sum_t'(y)
          + sum_t'(matrix[r * COLS + 2]) * sum_t'(z)
          + (sum_t'(matrix[r * COLS + 3]) <<< frac);
      q = acc >>> frac;
      if (q > Q_MAX) return coord_t'(Q_MAX);
      if (q < Q_MIN) return coord_t'(Q_MIN);
      return coord_t'(q);
    endfunction

    function void note_item(kind_t k, idx_t i, coord_t cv, coord_t x, coord_t y,
                            coord_t z);
      point_t p;
      if (k == KIND_LOAD) begin
        // bottom row is not kept
        if (i < COEFF_COUNT) matrix[i] = cv;
      end else begin
        p.x = row_result(0, x, y, z);
        p.y = row_result(1, x, y, z);
        p.z = row_result(2, x, y, z);
        due.push_back(p);
      end
    endfunction

    function void compare_field(string name, coord_t want, coord_t got);
      if (want !== got) begin
        $error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name, want, want, got, got);
        errors++;
      end
    endfunction

    function void check_result(coord_t x, coord_t y, coord_t z);
      point_t p;
      if (due.size() == 0) begin
        $error("result transfer with no transform outstanding: %0d %0d %0d", x, y, z);
        errors++;
        return;
      end
      p = due.pop_front();
      compare_field("out_x", p.x, x);
      compare_field("out_y", p.y, y);
      compare_field("out_z", p.z, z);
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

endpackage

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives coefficient loads and point transforms into the affine transform
// core with random idling on both channels, predicts every transformed point
// and checks each result transfer against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apt_pkg::*;
  import apt_tb_pkg::*;

  localparam int FRAC_BITS = 16;
  // limit for the run-away guard, set well above the longest expected run
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  localparam coord_t ONE  = coord_t'(1) <<< FRAC_BITS;
  localparam coord_t CMAX = coord_t'(32'h7FFF_FFFF);
  localparam coord_t CMIN = coord_t'(32'h8000_0000);

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_stall;
  logic   kind = KIND_LOAD;
  idx_t   coeff_index = '0;
  coord_t coeff_value = '0;
  coord_t point_x = '0;
  coord_t point_y = '0;
  coord_t point_z = '0;
  logic   result_valid;
  logic   result_stall = 1'b0;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;

  transform_board board = new(FRAC_BITS);

  // idling controls shared between the two sides
  bit gaps_on = 1'b1;     // random gaps on either side
  bit hold_req = 1'b0;    // ask the receiver for one long hold-off
  int unsigned cycle_count = 0;

  affine_point_transform_core #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .kind        (kind),
    .coeff_index (coeff_index),
    .coeff_value (coeff_value),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // mix of small values, full-range noise and the corner values
  function automatic coord_t pick_value(int unsigned span);
    case ($urandom_range(0, 9))
      0: return coord_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return CMAX;
          1: return CMIN;
          2: return '0;
          3: return ONE;
          default: return -ONE;
        endcase
      end
      default: return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
    endcase
  endfunction

  // one transfer on the item channel; valid stays up between back-to-back items
  task automatic offer(kind_t k, idx_t i, coord_t cv, coord_t x, coord_t y, coord_t z);
    int n;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 15);
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    item_valid  <= 1'b1;
    kind        <= k;
    coeff_index <= i;
    coeff_value <= cv;
    point_x     <= x;
    point_y     <= y;
    point_z     <= z;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item(k, i, cv, x, y, z);
  endtask

  // ignored fields carry random junk so that they are seen to be ignored
  task automatic load(idx_t i, coord_t v);
    offer(KIND_LOAD, i, v, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic transform(coord_t x, coord_t y, coord_t z);
    offer(KIND_POINT, idx_t'($urandom_range(0, 15)), coord_t'($urandom), x, y, z);
  endtask

  // bursts of coefficient loads between runs of points; mostly in-range
  // values so that results do not simply sit at the rails
  task automatic run_random(int count);
    int done_items;
    int burst;
    idx_t i;
    done_items = 0;
    while (done_items < count) begin
      if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          // now and then a bottom-row index, which must leave the matrix alone
          if ($urandom_range(0, 15) == 0) i = idx_t'($urandom_range(COEFF_COUNT, 15));
          else i = idx_t'($urandom_range(0, COEFF_COUNT - 1));
          load(i, pick_value(4 * ONE));
        end
        done_items += burst;
      end else begin
        transform(pick_value(1000 * ONE), pick_value(1000 * ONE), pick_value(1000 * ONE));
        done_items++;
      end
    end
  endtask

  // result side: check each transfer, then pick the stall for the next cycle
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) board.check_result(out_x, out_y, out_z);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        // long hold-off so the pipeline backs up into the item channel
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      result_stall <= (stall_left > 0);
    end
  end

  // main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity matrix straight after reset, extreme coordinates pass through
    transform('0, '0, '0);
    transform(CMAX, CMIN, ONE);
    transform(-1, -ONE, 1);
    // x translation at the top of the range: exact hit, then overflow
    load(3, CMAX);
    transform('0, 5, -5);
    transform(CMAX, '0, '0);
    // y translation at the bottom: exact hit, then underflow
    load(7, CMIN);
    transform('0, '0, '0);
    transform('0, CMIN, '0);
    // bottom-row loads are dropped
    load(12, CMAX);
    load(15, CMIN);
    // half scale on x: floor of plus and minus one half
    load(3, '0);
    load(0, ONE / 2);
    transform(1, '0, '0);
    transform(-1, '0, '0);
    // largest products in all three columns of one row, both signs
    load(4, CMIN);
    load(5, CMIN);
    load(6, CMIN);
    transform(CMIN, CMIN, CMIN);
    transform(CMAX, CMAX, CMAX);
    // z translation at the bottom, one lsb past it
    load(11, CMIN);
    transform('0, '0, -1);
    transform('0, '0, '0);

    run_random(600);

    // receiver holds off while points keep coming, so the core fills up
    hold_req = 1'b1;
    gaps_on  = 1'b0;
    repeat (80) transform(pick_value(1000 * ONE), pick_value(1000 * ONE),
                          pick_value(1000 * ONE));
    gaps_on = 1'b1;

    // sender pauses until the pipeline has drained
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);

    run_random(620);

    // last stretch at full rate on both sides
    gaps_on = 1'b0;
    run_random(200);
    item_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    // wait past the pipeline depth to catch stray results
    repeat (12) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
